// ===== design/mmc_pkg.sv =====
// ----------------------------------------------------------------------------
// Magnetometer calibrator package
// Shared types, codes and constants of the min/max calibrator.
// ----------------------------------------------------------------------------
`default_nettype none
package mmc_pkg;

  localparam int unsigned SampleWidthDefault = 16;
  localparam int unsigned DivWidth = 48;

  typedef enum logic [2:0] {
    OP_SAMPLE = 3'd0,
    OP_TICK   = 3'd1,
    OP_START  = 3'd2,
    OP_STOP   = 3'd3,
    OP_FINISH = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_RUN  = 2'd1,
    MODE_DONE = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_IGNORED  = 3'd0,
    ST_PROGRESS = 3'd1,
    ST_BUILT    = 3'd2,
    ST_MOTION   = 3'd3,
    ST_NOTRUN   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CFG_MIN_SAMPLES = 2'd0,
    CFG_MIN_SPAN    = 2'd1,
    CFG_COV_TARGET  = 2'd2,
    CFG_AUTO_FINISH = 2'd3
  } cfg_e;

  typedef enum logic [3:0] {
    C_IDLE,
    C_DECODE,
    C_PROG_A,
    C_PROG_AW,
    C_PROG_B,
    C_PROG_BW,
    C_CHECK,
    C_SCALE,
    C_SCALE_W,
    C_COMMIT,
    C_OUT
  } ctrl_e;

  typedef enum logic [2:0] {
    DV_NONE,
    DV_COV,
    DV_CNT,
    DV_SCALE
  } dsel_e;

  typedef struct packed {
    logic        load_item;
    logic        do_sample;
    logic        do_start;
    logic        do_stop;
    logic        arm_timer;
    logic        div_start;
    dsel_e       div_sel;
    logic [1:0]  axis;
    logic        take_a;
    logic        set_prog;
    logic        store_scale;
    logic        commit;
    logic        set_status;
    status_e     status;
    logic        out_load;
  } mmc_cmd_t;

  typedef struct packed {
    op_e         op;
    logic        avail;
    mode_e       mode;
    logic        armed;
    logic        timed_out;
    logic        can_build;
    logic        div_done;
  } mmc_sts_t;

endpackage
`default_nettype wire

// ===== design/mmc_divider.sv =====
// ----------------------------------------------------------------------------
// Magnetometer calibrator divider
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module mmc_divider (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [mmc_pkg::DivWidth-1:0] num_i,
  input  wire logic [mmc_pkg::DivWidth-1:0] den_i,
  output logic                             done_o,
  output logic [mmc_pkg::DivWidth-1:0]     quo_o
);
  import mmc_pkg::*;

  localparam int unsigned CntW = $clog2(DivWidth + 1);

  logic [DivWidth-1:0] rem_q, rem_d, quo_q, quo_d, den_q;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                busy_q, busy_d, done_q, done_d;
  logic [DivWidth:0]   trial;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[DivWidth-1]} - {1'b0, den_q};
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_i;
      cnt_d  = CntW'(DivWidth);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[DivWidth]) begin
        rem_d = trial[DivWidth-1:0];
        quo_d = {quo_q[DivWidth-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DivWidth-2:0], quo_q[DivWidth-1]};
        quo_d = {quo_q[DivWidth-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule
`default_nettype wire

// ===== design/mmc_datapath.sv =====
// ----------------------------------------------------------------------------
// Magnetometer calibrator datapath
// Capture registers, bounds, configuration and calibration result storage.
// ----------------------------------------------------------------------------
`default_nettype none
module mmc_datapath #(
  parameter int unsigned SampleWidth = mmc_pkg::SampleWidthDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire mmc_pkg::mmc_cmd_t    cmd_i,
  output mmc_pkg::mmc_sts_t         sts_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [1:0]           cfg_idx_i,
  input  wire logic [31:0]          cfg_data_i,
  input  wire logic [2:0]           op_i,
  input  wire logic [15:0]          mag_x_i,
  input  wire logic [15:0]          mag_y_i,
  input  wire logic [15:0]          mag_z_i,
  input  wire logic                 avail_i,
  input  wire logic [31:0]          now_i,
  output logic [1:0]                run_state_o,
  output logic [2:0]                status_o,
  output logic [8:0]                progress_o,
  output logic                      cal_valid_o,
  output logic [16:0]               offset_x_o,
  output logic [16:0]               offset_y_o,
  output logic [16:0]               offset_z_o,
  output logic [15:0]               scale_x_o,
  output logic [15:0]               scale_y_o,
  output logic [15:0]               scale_z_o
);
  import mmc_pkg::*;

  localparam int unsigned SpanW = SampleWidth + 1;

  logic [15:0] min_samples_q, min_span_q, cov_q;
  logic [31:0] auto_q;
  logic [2:0]  op_q;
  logic        avail_q;
  logic [31:0] now_q;
  logic signed [SampleWidth-1:0] smp_q [3];
  logic signed [SampleWidth-1:0] lo_q [3];
  logic signed [SampleWidth-1:0] hi_q [3];
  logic [SpanW-1:0] span [3];
  logic [SpanW-1:0] least;
  logic [SpanW+1:0] sum;
  mode_e       mode_q;
  logic        seen_q, armed_q, valid_q;
  logic [15:0] cnt_q;
  logic [31:0] start_q;
  logic [8:0]  prog_q, ratio_a_q, ratio;
  logic [16:0] off_q [3];
  logic [15:0] scl_q [3];
  status_e     status_q;
  logic [DivWidth-1:0] num, den, quo;
  logic        div_done;
  logic [15:0] smp_in [3];
  logic [31:0] elapsed;

  assign smp_in[0] = mag_x_i;
  assign smp_in[1] = mag_y_i;
  assign smp_in[2] = mag_z_i;

  mmc_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (num),
    .den_i  (den),
    .done_o (div_done),
    .quo_o  (quo)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      span[i] = SpanW'({hi_q[i][SampleWidth-1], hi_q[i]} - {lo_q[i][SampleWidth-1], lo_q[i]});
    end
    least = span[0];
    if (span[1] < least) least = span[1];
    if (span[2] < least) least = span[2];
    sum = (SpanW+2)'(span[0]) + (SpanW+2)'(span[1]) + (SpanW+2)'(span[2]);
  end

  always_comb begin
    num = '0;
    den = '0;
    unique case (cmd_i.div_sel)
      DV_COV: begin
        num = DivWidth'({least, 8'd0});
        den = DivWidth'(cov_q);
      end
      DV_CNT: begin
        num = DivWidth'({cnt_q, 8'd0});
        den = DivWidth'(min_samples_q);
      end
      DV_SCALE: begin
        num = DivWidth'({sum, 13'd0}) + DivWidth'(span[cmd_i.axis]) * DivWidth'(3);
        den = DivWidth'(span[cmd_i.axis]) * DivWidth'(6);
      end
      default: ;
    endcase
  end

  always_comb begin
    if ((cmd_i.div_sel == DV_COV && cov_q == '0) ||
        (cmd_i.div_sel == DV_CNT && min_samples_q == '0) ||
        quo > DivWidth'(256)) begin
      ratio = 9'd256;
    end else begin
      ratio = quo[8:0];
    end
  end

  assign elapsed = now_q - start_q;

  assign sts_o.op        = op_e'(op_q);
  assign sts_o.avail     = avail_q;
  assign sts_o.mode      = mode_q;
  assign sts_o.armed     = armed_q;
  assign sts_o.timed_out = elapsed >= auto_q;
  assign sts_o.can_build = seen_q && cnt_q >= min_samples_q &&
                           span[0] >= SpanW'(min_span_q) &&
                           span[1] >= SpanW'(min_span_q) &&
                           span[2] >= SpanW'(min_span_q);
  assign sts_o.div_done  = div_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_samples_q <= 16'd20;
      min_span_q    <= 16'd1;
      cov_q         <= 16'd5120;
      auto_q        <= 32'd20000;
      mode_q        <= MODE_IDLE;
      seen_q        <= 1'b0;
      armed_q       <= 1'b0;
      valid_q       <= 1'b0;
      cnt_q         <= '0;
      start_q       <= '0;
      prog_q        <= '0;
      status_q      <= ST_IGNORED;
      for (int i = 0; i < 3; i++) begin
        lo_q[i]  <= '0;
        hi_q[i]  <= '0;
        off_q[i] <= '0;
        scl_q[i] <= 16'd4096;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_e'(cfg_idx_i))
          CFG_MIN_SAMPLES: min_samples_q <= cfg_data_i[15:0];
          CFG_MIN_SPAN:    min_span_q    <= cfg_data_i[15:0];
          CFG_COV_TARGET:  cov_q         <= cfg_data_i[15:0];
          CFG_AUTO_FINISH: auto_q        <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.do_start) begin
        mode_q  <= MODE_RUN;
        seen_q  <= 1'b0;
        armed_q <= 1'b0;
        cnt_q   <= '0;
        start_q <= '0;
        prog_q  <= '0;
        for (int i = 0; i < 3; i++) begin
          lo_q[i] <= '0;
          hi_q[i] <= '0;
        end
      end
      if (cmd_i.do_stop) begin
        mode_q <= MODE_IDLE;
      end
      if (cmd_i.arm_timer) begin
        armed_q <= 1'b1;
        start_q <= now_q;
      end
      if (cmd_i.do_sample) begin
        for (int i = 0; i < 3; i++) begin
          if (!seen_q || smp_q[i] < lo_q[i]) lo_q[i] <= smp_q[i];
          if (!seen_q || smp_q[i] > hi_q[i]) hi_q[i] <= smp_q[i];
        end
        seen_q <= 1'b1;
        if (cnt_q != 16'hFFFF) cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.set_prog) begin
        prog_q <= (ratio_a_q < ratio) ? ratio_a_q : ratio;
      end
      if (cmd_i.store_scale) begin
        if (span[cmd_i.axis] == '0) begin
          scl_q[cmd_i.axis] <= (sum == '0) ? 16'd4096 : 16'hFFFF;
        end else if (quo > DivWidth'(16'hFFFF)) begin
          scl_q[cmd_i.axis] <= 16'hFFFF;
        end else begin
          scl_q[cmd_i.axis] <= quo[15:0];
        end
      end
      if (cmd_i.commit) begin
        for (int i = 0; i < 3; i++) begin
          off_q[i] <= 17'({hi_q[i][SampleWidth-1], hi_q[i]} + {lo_q[i][SampleWidth-1], lo_q[i]});
        end
        valid_q <= 1'b1;
        prog_q  <= 9'd256;
        mode_q  <= MODE_DONE;
      end
      if (cmd_i.set_status) begin
        status_q <= cmd_i.status;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q    <= op_i;
      avail_q <= avail_i;
      now_q   <= now_i;
      for (int i = 0; i < 3; i++) begin
        smp_q[i] <= smp_in[i][SampleWidth-1:0];
      end
    end
    if (cmd_i.take_a) begin
      ratio_a_q <= ratio;
    end
    if (cmd_i.out_load) begin
      run_state_o <= mode_q;
      status_o    <= status_q;
      progress_o  <= prog_q;
      cal_valid_o <= valid_q;
      offset_x_o  <= off_q[0];
      offset_y_o  <= off_q[1];
      offset_z_o  <= off_q[2];
      scale_x_o   <= scl_q[0];
      scale_y_o   <= scl_q[1];
      scale_z_o   <= scl_q[2];
    end
  end
endmodule
`default_nettype wire

// ===== design/mmc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Magnetometer calibrator controller
// Sequences one event through decode, divisions, commit and output.
// ----------------------------------------------------------------------------
`default_nettype none
module mmc_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire mmc_pkg::mmc_sts_t sts_i,
  output mmc_pkg::mmc_cmd_t      cmd_o
);
  import mmc_pkg::*;

  ctrl_e      state_q, state_d;
  logic [1:0] axis_q, axis_d;
  logic       ovalid_q, ovalid_d;

  always_comb begin
    state_d  = state_q;
    axis_d   = axis_q;
    ovalid_d = ovalid_q;
    cmd_o    = '0;
    if (out_ready_i) ovalid_d = 1'b0;
    in_ready_o = (state_q == C_IDLE);
    cmd_o.axis = axis_q;
    unique case (state_q)
      C_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = C_DECODE;
        end
      end
      C_DECODE: begin
        cmd_o.set_status = 1'b1;
        cmd_o.status     = ST_IGNORED;
        state_d          = C_OUT;
        priority case (sts_i.op)
          OP_START: begin
            cmd_o.do_start = 1'b1;
            cmd_o.status   = ST_PROGRESS;
          end
          OP_STOP: cmd_o.do_stop = 1'b1;
          OP_SAMPLE: begin
            if (sts_i.mode != MODE_RUN) begin
              cmd_o.status = ST_NOTRUN;
            end else if (sts_i.avail) begin
              cmd_o.do_sample = 1'b1;
              cmd_o.status    = ST_PROGRESS;
              state_d         = C_PROG_A;
            end
          end
          OP_TICK: begin
            if (sts_i.mode != MODE_RUN) begin
              cmd_o.status = ST_NOTRUN;
            end else if (!sts_i.armed) begin
              cmd_o.arm_timer = 1'b1;
            end else if (sts_i.timed_out) begin
              state_d = C_CHECK;
            end
          end
          OP_FINISH: begin
            if (sts_i.mode != MODE_RUN) cmd_o.status = ST_NOTRUN;
            else state_d = C_CHECK;
          end
          default: ;
        endcase
      end
      C_PROG_A: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DV_COV;
        state_d         = C_PROG_AW;
      end
      C_PROG_AW: begin
        cmd_o.div_sel = DV_COV;
        if (sts_i.div_done) begin
          cmd_o.take_a = 1'b1;
          state_d      = C_PROG_B;
        end
      end
      C_PROG_B: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DV_CNT;
        state_d         = C_PROG_BW;
      end
      C_PROG_BW: begin
        cmd_o.div_sel = DV_CNT;
        if (sts_i.div_done) begin
          cmd_o.set_prog = 1'b1;
          state_d        = C_OUT;
        end
      end
      C_CHECK: begin
        cmd_o.set_status = 1'b1;
        if (sts_i.can_build) begin
          cmd_o.status = ST_BUILT;
          axis_d       = 2'd0;
          state_d      = C_SCALE;
        end else begin
          cmd_o.status = ST_MOTION;
          state_d      = C_OUT;
        end
      end
      C_SCALE: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DV_SCALE;
        state_d         = C_SCALE_W;
      end
      C_SCALE_W: begin
        cmd_o.div_sel = DV_SCALE;
        if (sts_i.div_done) begin
          cmd_o.store_scale = 1'b1;
          if (axis_q == 2'd2) begin
            state_d = C_COMMIT;
          end else begin
            axis_d  = axis_q + 1'b1;
            state_d = C_SCALE;
          end
        end
      end
      C_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = C_OUT;
      end
      C_OUT: begin
        if (!ovalid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          ovalid_d       = 1'b1;
          state_d        = C_IDLE;
        end
      end
      default: state_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= C_IDLE;
      axis_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      axis_q   <= axis_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign out_valid_o = ovalid_q;
endmodule
`default_nettype wire

// ===== design/magnetometer_minmax_calibrator.sv =====
// ----------------------------------------------------------------------------
// Magnetometer min/max calibrator
// Tracks per-axis bounds of magnetometer samples and builds hard- and
// soft-iron calibration values on request.
// ----------------------------------------------------------------------------
// Channel  Direction  Contents
// s_axis   in         event transaction: op in tuser, readings and time in tdata
// m_axis   out        result transaction: state, status, progress, calibration
// cfg      in         register index and write data
//
// A taken sample runs two 48-step divisions in the shared divider; a
// finish that builds a calibration runs three. One transaction is in
// work at a time; the result register frees the core while the result
// waits. Reset is asynchronous and active low.
`default_nettype none
module magnetometer_minmax_calibrator #(
  parameter int unsigned SampleWidth = mmc_pkg::SampleWidthDefault
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // tdata: mag_x, mag_y, mag_z, sample_available, now_ms (bits 0..80), zero pad
  input  wire logic [87:0]  s_axis_tdata,
  // tuser: op
  input  wire logic [2:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // tdata: run_state, status, progress, cal_valid, offset_x, offset_y,
  // offset_z, scale_x, scale_y, scale_z (bits 0..113), zero pad
  output logic [119:0]      m_axis_tdata,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [1:0]   cfg_index_i,
  input  wire logic [31:0]  cfg_data_i
);
  import mmc_pkg::*;

  mmc_cmd_t    cmd;
  mmc_sts_t    sts;
  logic [1:0]  run_state;
  logic [2:0]  status;
  logic [8:0]  progress;
  logic        cal_valid;
  logic [16:0] off_x, off_y, off_z;
  logic [15:0] scl_x, scl_y, scl_z;

  assign cfg_ready_o = 1'b1;

  mmc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mmc_datapath #(.SampleWidth(SampleWidth)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_valid_i),
    .cfg_idx_i   (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .op_i        (s_axis_tuser),
    .mag_x_i     (s_axis_tdata[15:0]),
    .mag_y_i     (s_axis_tdata[31:16]),
    .mag_z_i     (s_axis_tdata[47:32]),
    .avail_i     (s_axis_tdata[48]),
    .now_i       (s_axis_tdata[80:49]),
    .run_state_o (run_state),
    .status_o    (status),
    .progress_o  (progress),
    .cal_valid_o (cal_valid),
    .offset_x_o  (off_x),
    .offset_y_o  (off_y),
    .offset_z_o  (off_z),
    .scale_x_o   (scl_x),
    .scale_y_o   (scl_y),
    .scale_z_o   (scl_z)
  );

  assign m_axis_tdata = {6'd0, scl_z, scl_y, scl_x, off_z, off_y, off_x,
                         cal_valid, progress, status, run_state};
endmodule
`default_nettype wire
